FILE: sv/pls_pkg.sv
// shared types and codes for the positional list store
package pls_pkg;

    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int POS_W   = 6;
    localparam int TOTAL_W = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FIRST = 3'd0,
        CMD_INS_LAST  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FIRST = 3'd3,
        CMD_DEL_LAST  = 3'd4,
        CMD_DEL_AT    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // shift command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic del;
    } cell_op_t;

endpackage

FILE: sv/positional_list_store.sv
// positional list store: bounded ordered list of signed values in a chain of shifting cells
// latency: a request accepted at one edge shows its response from the next cycle on
// throughput: one request per cycle while the response is not stalled; every cell shifts in parallel in the same cycle
// a request is taken while the response register is empty or being drained
// reset clears the element count and the response valid flag; entry data is not reset
// an entry is only read once written, so no clearing pass follows reset
module positional_list_store #(
    parameter int CAPACITY = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [pls_pkg::CMD_W-1:0]          cmd,
    input  logic signed [pls_pkg::DATA_W-1:0]  value,
    input  logic [pls_pkg::POS_W-1:0]          position,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [1:0]                         status,
    output logic signed [pls_pkg::DATA_W-1:0]  removed_value,
    output logic [pls_pkg::TOTAL_W-1:0]        element_total
);
    import pls_pkg::*;

    localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [MW-1:0] CAP_M = MW'(CAPACITY);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    status_t             status_reg;
    status_t             status_next;
    logic signed [DATA_W-1:0] removed_reg;
    logic signed [DATA_W-1:0] removed_next;
    logic [TOTAL_W-1:0]  total_reg;

    logic                accept;
    cell_op_t            op;
    logic [IW-1:0]       idx;
    logic [MW-1:0]       pos_m;
    logic [MW-1:0]       count_m;
    logic [MW-1:0]       pos_less_one;
    logic [MW-1:0]       count_less_one;

    logic signed [DATA_W-1:0] cell_data  [CAPACITY];
    logic signed [DATA_W-1:0] left_arr   [CAPACITY];
    logic signed [DATA_W-1:0] right_arr  [CAPACITY];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign pos_m          = MW'(position);
    assign count_m        = MW'(count_reg);
    assign pos_less_one   = pos_m - MW'(1);
    assign count_less_one = count_m - MW'(1);

    always_comb
    begin
        op           = '0;
        idx          = '0;
        status_next  = ST_OK;
        removed_next = '0;
        count_next   = count_reg;
        unique case (cmd_t'(cmd))
            CMD_INS_FIRST, CMD_INS_LAST:
            begin
                if (count_m >= CAP_M)
                    status_next = ST_FULL;
                else
                begin
                    op.ins     = accept;
                    idx        = (cmd_t'(cmd) == CMD_INS_FIRST) ? '0 : count_m[IW-1:0];
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_INS_AT:
            begin
                // position is checked before fullness
                if (pos_m == '0 || pos_m > count_m + MW'(1))
                    status_next = ST_BADPOS;
                else if (count_m >= CAP_M)
                    status_next = ST_FULL;
                else
                begin
                    op.ins     = accept;
                    idx        = pos_less_one[IW-1:0];
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_DEL_FIRST, CMD_DEL_LAST:
            begin
                if (count_m == '0)
                    status_next = ST_EMPTY;
                else
                begin
                    op.del       = accept;
                    idx          = (cmd_t'(cmd) == CMD_DEL_FIRST) ? '0
                                                                  : count_less_one[IW-1:0];
                    removed_next = cell_data[idx];
                    count_next   = count_reg - CW'(1);
                end
            end
            CMD_DEL_AT:
            begin
                if (pos_m == '0 || pos_m > count_m)
                    status_next = ST_BADPOS;
                else
                begin
                    op.del       = accept;
                    idx          = pos_less_one[IW-1:0];
                    removed_next = cell_data[idx];
                    count_next   = count_reg - CW'(1);
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign left_arr[gi] = value;
            end
            else
            begin : g_mid_l
                assign left_arr[gi] = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_arr[gi] = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign right_arr[gi] = cell_data[gi+1];
            end

            pls_cell #(
                .IW    (IW),
                .INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .op         (op),
                .idx        (idx),
                .value      (value),
                .left_data  (left_arr[gi]),
                .right_data (right_arr[gi]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    // element total wraps modulo 64 for large capacities
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            total_reg   <= TOTAL_W'(count_next);
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign element_total = total_reg;

endmodule

FILE: sv/pls_cell.sv
// one storage cell of the shifting entry chain
module pls_cell #(
    parameter int IW    = 5,
    parameter int INDEX = 0
) (
    input  logic                         clk,
    input  pls_pkg::cell_op_t            op,
    input  logic [IW-1:0]                idx,
    input  logic signed [pls_pkg::DATA_W-1:0] value,
    input  logic signed [pls_pkg::DATA_W-1:0] left_data,
    input  logic signed [pls_pkg::DATA_W-1:0] right_data,
    output logic signed [pls_pkg::DATA_W-1:0] data
);
    import pls_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (op.ins)
        begin
            if (MY_IDX > idx)
                data_next = left_data;
            else if (MY_IDX == idx)
                data_next = value;
        end
        else if (op.del)
        begin
            // everything from the removed slot onward moves toward the front
            if (MY_IDX >= idx)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: sv/pls_checker.sv
// port-level checks for the positional list store
module pls_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_stall,
    input logic                               rsp_valid,
    input logic                               rsp_stall,
    input logic [1:0]                         status,
    input logic signed [pls_pkg::DATA_W-1:0]  removed_value,
    input logic [pls_pkg::TOTAL_W-1:0]        element_total
);
    import pls_pkg::*;

    // every accepted request leaves a response behind
    a_req_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> rsp_valid)
    else $error("accepted request produced no response");

    // requests are held back only by a pending response that is stalled
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall == (rsp_valid && rsp_stall))
    else $error("request stall does not follow response backpressure");

    // a failed command removes nothing
    a_no_removal_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> removed_value == '0)
    else $error("removed value nonzero on failed command");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status)
            && $stable(removed_value) && $stable(element_total))
    else $error("stalled response changed");

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);

FILE: verif/tb_top.sv
// self-checking testbench for the positional list store with random handshake idling
module tb_top;

    import pls_pkg::*;

    localparam int          LIST_DEPTH      = 32;
    localparam int          ITEM_TARGET     = 1550;
    localparam int          PRESSURE_CYCLES = 250;
    localparam int          DRAIN_CYCLES    = 20;
    localparam logic [2:0]  CMD_SPARE_6     = 3'd6;
    localparam logic [2:0]  CMD_SPARE_7     = 3'd7;

    typedef struct packed {
        status_t     status;
        logic [31:0] removed;
        logic [5:0]  total;
    } list_rsp_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] val;
        logic [5:0]  pos;
        logic        fixed;
        list_rsp_t   rsp;
    } dir_row_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        req_valid     = 1'b0;
    logic        req_stall;
    logic [2:0]  cmd           = '0;
    logic [31:0] value         = '0;
    logic [5:0]  position      = '0;
    logic        rsp_valid;
    logic        rsp_stall     = 1'b0;
    logic [1:0]  status;
    logic [31:0] removed_value;
    logic [5:0]  element_total;

    logic [31:0] list_q[$];
    list_rsp_t   rsp_expect_q[$];
    int          mismatch_count = 0;
    int          responses_seen = 0;
    int          sent_count     = 0;

    positional_list_store #(
        .CAPACITY(LIST_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .cmd          (cmd),
        .value        (value),
        .position     (position),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .removed_value(removed_value),
        .element_total(element_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("CHECK FAILED");
        $finish;
    end

    // applies one request to the list copy and returns the response it should give
    function automatic list_rsp_t apply_command(input logic [2:0] op, input logic [31:0] val,
                                                input logic [5:0] pos);
        list_rsp_t r;
        r.status  = ST_OK;
        r.removed = '0;
        case (op)
            CMD_INS_FIRST:
                if (list_q.size() >= LIST_DEPTH) r.status = ST_FULL;
                else list_q.push_front(val);
            CMD_INS_LAST:
                if (list_q.size() >= LIST_DEPTH) r.status = ST_FULL;
                else list_q.push_back(val);
            CMD_INS_AT:
                // position is checked before the full condition
                if (pos < 1 || pos > list_q.size() + 1) r.status = ST_BADPOS;
                else if (list_q.size() >= LIST_DEPTH) r.status = ST_FULL;
                else list_q.insert(pos - 1, val);
            CMD_DEL_FIRST:
                if (list_q.size() == 0) r.status = ST_EMPTY;
                else r.removed = list_q.pop_front();
            CMD_DEL_LAST:
                if (list_q.size() == 0) r.status = ST_EMPTY;
                else r.removed = list_q.pop_back();
            CMD_DEL_AT:
                if (pos < 1 || pos > list_q.size()) r.status = ST_BADPOS;
                else
                begin
                    r.removed = list_q[pos - 1];
                    list_q.delete(pos - 1);
                end
            default: ;
        endcase
        r.total = 6'(list_q.size());
        return r;
    endfunction

    // mostly short gaps, some none, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        else if (roll < 92) return $urandom_range(1, 3);
        else return $urandom_range(10, 40);
    endfunction

    function automatic dir_row_t dir_row(input logic [2:0] op, input logic [31:0] val,
                                         input logic [5:0] pos, input logic fixed,
                                         input status_t st, input logic [31:0] rem,
                                         input logic [5:0] tot);
        dir_row_t r;
        r.op          = op;
        r.val         = val;
        r.pos         = pos;
        r.fixed       = fixed;
        r.rsp.status  = st;
        r.rsp.removed = rem;
        r.rsp.total   = tot;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        $display("%0t: response %0d %s mismatch, expected %0h, got %0h",
                 $time, responses_seen, what, want, got);
    endtask

    task automatic issue_request(input logic [2:0] op, input logic [31:0] val,
                                 input logic [5:0] pos, input logic fixed,
                                 input list_rsp_t fixed_rsp);
        list_rsp_t   predicted;
        int unsigned gap;
        req_valid <= 1'b1;
        cmd       <= op;
        value     <= val;
        position  <= pos;
        do @(posedge clk); while (req_stall);
        predicted = apply_command(op, val, pos);
        rsp_expect_q.push_back(fixed ? fixed_rsp : predicted);
        sent_count++;
        gap = pick_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // response side: random stalls plus one long hold-off to back up the block
    initial
    begin
        int unsigned stall_len;
        bit          hold_done;
        hold_done = 1'b0;
        forever
        begin
            if (!hold_done && responses_seen >= 300)
            begin
                stall_len = PRESSURE_CYCLES;
                hold_done = 1'b1;
            end
            else
                stall_len = pick_gap();
            if (stall_len != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        list_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            responses_seen++;
            if (rsp_expect_q.size() == 0)
                report_mismatch("unexpected response, status", '0, 32'(status));
            else
            begin
                want = rsp_expect_q.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(status));
                if (removed_value !== want.removed)
                    report_mismatch("removed_value", want.removed, removed_value);
                if (element_total !== want.total)
                    report_mismatch("element_total", 32'(want.total), 32'(element_total));
            end
        end
    end

    initial
    begin
        dir_row_t    dir_table [21];
        logic [2:0]  op;
        logic [31:0] val;
        logic [5:0]  pos;
        int unsigned bias;
        int unsigned grow;
        int unsigned kind;
        int unsigned burst;
        int unsigned span;

        dir_table = '{
            dir_row(CMD_DEL_FIRST, 32'h0,         6'd0,  1'b1, ST_EMPTY,  32'h0, 6'd0),
            dir_row(CMD_DEL_LAST,  32'h0,         6'd0,  1'b1, ST_EMPTY,  32'h0, 6'd0),
            dir_row(CMD_DEL_AT,    32'h0,         6'd1,  1'b1, ST_BADPOS, 32'h0, 6'd0),
            dir_row(CMD_DEL_AT,    32'h0,         6'd0,  1'b1, ST_BADPOS, 32'h0, 6'd0),
            dir_row(CMD_INS_AT,    32'h5,         6'd0,  1'b1, ST_BADPOS, 32'h0, 6'd0),
            dir_row(CMD_INS_AT,    32'h5,         6'd2,  1'b1, ST_BADPOS, 32'h0, 6'd0),
            dir_row(CMD_INS_AT,    32'h7fff_ffff, 6'd1,  1'b1, ST_OK,     32'h0, 6'd1),
            dir_row(CMD_INS_FIRST, 32'h8000_0000, 6'd0,  1'b1, ST_OK,     32'h0, 6'd2),
            dir_row(CMD_INS_LAST,  32'hffff_ffff, 6'd63, 1'b1, ST_OK,     32'h0, 6'd3),
            dir_row(CMD_SPARE_6,   32'h1234_5678, 6'd63, 1'b1, ST_OK,     32'h0, 6'd3),
            dir_row(CMD_SPARE_7,   32'hffff_ffff, 6'd1,  1'b1, ST_OK,     32'h0, 6'd3),
            dir_row(CMD_INS_AT,    32'h0,         6'd4,  1'b1, ST_OK,     32'h0, 6'd4),
            dir_row(CMD_DEL_AT,    32'h0,         6'd63, 1'b1, ST_BADPOS, 32'h0, 6'd4),
            dir_row(CMD_INS_AT,    32'h0,         6'd63, 1'b1, ST_BADPOS, 32'h0, 6'd4),
            dir_row(CMD_DEL_AT,    32'h0,         6'd2,  1'b0, ST_OK,     32'h0, 6'd0),
            dir_row(CMD_INS_AT,    32'ha5a5_5a5a, 6'd2,  1'b0, ST_OK,     32'h0, 6'd0),
            dir_row(CMD_DEL_FIRST, 32'h0,         6'd0,  1'b0, ST_OK,     32'h0, 6'd0),
            dir_row(CMD_DEL_LAST,  32'h0,         6'd0,  1'b0, ST_OK,     32'h0, 6'd0),
            dir_row(CMD_DEL_AT,    32'h0,         6'd1,  1'b0, ST_OK,     32'h0, 6'd0),
            dir_row(CMD_DEL_AT,    32'h0,         6'd1,  1'b0, ST_OK,     32'h0, 6'd0),
            dir_row(CMD_DEL_LAST,  32'h0,         6'd0,  1'b1, ST_EMPTY,  32'h0, 6'd0)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(dir_table); i++)
            issue_request(dir_table[i].op, dir_table[i].val, dir_table[i].pos,
                          dir_table[i].fixed, dir_table[i].rsp);

        // bursts that lean toward filling, draining or neither, so full and empty recur
        while (sent_count < ITEM_TARGET)
        begin
            bias  = $urandom_range(0, 2);
            grow  = (bias == 0) ? 80 : (bias == 1) ? 20 : 50;
            burst = $urandom_range(8, 60);
            repeat (burst)
            begin
                kind = $urandom_range(0, 2);
                if ($urandom_range(0, 99) < 4)
                    op = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
                else if ($urandom_range(0, 99) < grow)
                    op = (kind == 0) ? CMD_INS_FIRST : (kind == 1) ? CMD_INS_LAST : CMD_INS_AT;
                else
                    op = (kind == 0) ? CMD_DEL_FIRST : (kind == 1) ? CMD_DEL_LAST : CMD_DEL_AT;

                span = list_q.size() + ((op == CMD_INS_AT) ? 1 : 0);
                if (span > 0 && $urandom_range(0, 99) < 85)
                    pos = 6'($urandom_range(1, span));
                else
                    pos = 6'($urandom_range(0, 63));

                if ($urandom_range(0, 9) == 0)
                    case ($urandom_range(0, 3))
                        0:       val = 32'h8000_0000;
                        1:       val = 32'h7fff_ffff;
                        2:       val = 32'h0;
                        default: val = 32'hffff_ffff;
                    endcase
                else
                    val = $urandom;

                issue_request(op, val, pos, 1'b0, '0);
            end
        end
        req_valid <= 1'b0;

        while (rsp_expect_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
